FILE: rtl/core/framed_packet_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// framed packet receiver assertion macros
// shared concurrent assertion forms for the receiver rtl
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define FRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define FRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// types, constants and checksum helpers for the framed packet receiver
// ----------------------------------------------------------------------------
package frp_pkg;

    // sync word, first byte on the line first
    localparam logic [7:0] SYNC_B0 = 8'hED;
    localparam logic [7:0] SYNC_B1 = 8'h87;
    localparam logic [7:0] SYNC_B2 = 8'h17;
    localparam logic [7:0] SYNC_B3 = 8'h9A;

    // checksum seed and register reset
    localparam logic [31:0] SUM_SEED         = 32'h1234_5678;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

    // status codes on the end-of-packet result
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LEN_ERR = 2'd1;
    localparam logic [1:0] ST_SUM_ERR = 2'd2;

    // one result request
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] packet_length;
    } t_result;

    // expected sync byte at a given match position
    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = SYNC_B0;
            2'd1:    b = SYNC_B1;
            2'd2:    b = SYNC_B2;
            default: b = SYNC_B3;
        endcase
        return b;
    endfunction

    // add with wrap, then shift left one xor arithmetic shift right 23
    function automatic logic [31:0] sum_update(input logic [31:0] s, input logic [7:0] b);
        logic [31:0] t;
        t = s + {24'd0, b};
        return {t[30:0], 1'b0} ^ {{23{t[31]}}, t[31:23]};
    endfunction

    // fold the sum to one byte
    function automatic logic [7:0] sum_fold(input logic [31:0] s);
        return s[7:0] ^ s[15:8] ^ s[23:16];
    endfunction

endpackage

FILE: rtl/core/frp_in_if.sv
// ----------------------------------------------------------------------------
// frp_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/frp_out_if.sv
// ----------------------------------------------------------------------------
// frp_out_if
// result channel: payload bytes and end-of-packet status
// ----------------------------------------------------------------------------
interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] packet_length;

    modport source (output valid, output data_byte, output last, output status,
                    output packet_length, input ready);
    modport sink   (input valid, input data_byte, input last, input status,
                    input packet_length, output ready);
endinterface

FILE: rtl/core/frp_parser.sv
// ----------------------------------------------------------------------------
// frp_parser
// sync hunt, header decode, payload count and checksum for one byte a cycle while i_valid is high
// ----------------------------------------------------------------------------
`include "framed_packet_receiver_top_defines.svh"

module frp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic [15:0]      i_max_length,
    output logic             o_res_valid,
    output frp_pkg::t_result o_res
);
    import frp_pkg::*;

    // phase codes
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]  r_phase,       n_phase;
    logic [1:0]  r_sync_index,  n_sync_index;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_header_len,  n_header_len;
    logic [15:0] r_bytes_left,  n_bytes_left;
    logic [31:0] r_sum,         n_sum;

    logic [31:0] sum_next;
    logic [15:0] len_rx;
    logic [15:0] left_dec;

    assign sum_next = sum_update(r_sum, i_rx_byte);
    assign len_rx   = {r_length_high, i_rx_byte};
    assign left_dec = r_bytes_left - 16'd1;

    // next state and result for the accepted byte
    always_comb begin
        n_phase       = r_phase;
        n_sync_index  = r_sync_index;
        n_length_high = r_length_high;
        n_header_len  = r_header_len;
        n_bytes_left  = r_bytes_left;
        n_sum         = r_sum;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (i_valid) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte != sync_byte(r_sync_index)) begin
                        n_sync_index = 2'd0;
                    end else if (r_sync_index == 2'd3) begin
                        n_sync_index = 2'd0;
                        n_sum        = SUM_SEED;
                        n_phase      = PH_LEN_HI;
                    end else begin
                        n_sync_index = r_sync_index + 2'd1;
                    end
                end
                PH_LEN_HI: begin
                    n_length_high = i_rx_byte;
                    n_sum         = sum_next;
                    n_phase       = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_header_len = len_rx;
                    n_sum        = sum_next;
                    if (len_rx > i_max_length) begin
                        n_phase             = PH_HUNT;
                        n_sync_index        = 2'd0;
                        o_res_valid         = 1'b1;
                        o_res.last          = 1'b1;
                        o_res.status        = ST_LEN_ERR;
                        o_res.packet_length = len_rx;
                    end else begin
                        n_bytes_left = len_rx;
                        n_phase      = (len_rx == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum               = sum_next;
                    n_bytes_left        = left_dec;
                    if (left_dec == 16'd0) begin
                        n_phase = PH_CHECK;
                    end
                    o_res_valid         = 1'b1;
                    o_res.data_byte     = i_rx_byte;
                    o_res.status        = ST_OK;
                    o_res.packet_length = r_header_len;
                end
                PH_CHECK: begin
                    n_phase             = PH_HUNT;
                    n_sync_index        = 2'd0;
                    o_res_valid         = 1'b1;
                    o_res.last          = 1'b1;
                    o_res.status        = (sum_fold(r_sum) == i_rx_byte) ? ST_OK : ST_SUM_ERR;
                    o_res.packet_length = r_header_len;
                end
                default: begin
                    n_phase      = PH_HUNT;
                    n_sync_index = 2'd0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_sync_index  <= 2'd0;
            r_length_high <= 8'd0;
            r_header_len  <= 16'd0;
            r_bytes_left  <= 16'd0;
            r_sum         <= SUM_SEED;
        end else begin
            r_phase       <= n_phase;
            r_sync_index  <= n_sync_index;
            r_length_high <= n_length_high;
            r_header_len  <= n_header_len;
            r_bytes_left  <= n_bytes_left;
            r_sum         <= n_sum;
        end
    end

    // sync matching only runs while hunting
    `FRP_ASSERT_NOW(a_sync_only_hunt, i_clk, i_rst_n, r_sync_index != 2'd0, r_phase == PH_HUNT, "sync index set outside hunt")
    // payload phase always has bytes still to come
    `FRP_ASSERT_NOW(a_payload_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_bytes_left != 16'd0, "payload phase with no bytes left")

endmodule

FILE: rtl/core/framed_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_top
// framed packet receiver with registered, skid-buffered result channel
// ----------------------------------------------------------------------------
// usage:
//   i_rx carries received bytes one request at a time. after the sync word
//   ED 87 17 9A a 16-bit big-endian length follows, then the payload bytes,
//   then one checksum byte. each payload byte comes out on o_res with last
//   low; the checksum byte (or a length above max_length) gives one status
//   request with last high. sync bytes and a length within max_length give no result.
//   i_cfg_we / i_cfg_wdata write max_length; write it only while idle.
// timing:
//   one byte is taken every cycle while i_rx.ready is high. each result is
//   registered in the output register, or in the skid stage while a result waits.
// reset:
//   synchronous active low; the parser returns to sync hunt, max_length
//   goes to 512 and both result registers empty.
// stall:
//   a two-entry output register plus skid stage holds one more result while
//   a result waits; i_rx.ready drops once the skid stage is full.
// ----------------------------------------------------------------------------
`include "framed_packet_receiver_top_defines.svh"

module framed_packet_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    frp_in_if.sink      i_rx,
    frp_out_if.source   o_res
);
    import frp_pkg::*;

    logic [15:0] r_max_length;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        accept;
    logic        pop;
    logic        push;
    t_result     new_res;

    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && !r_skid_valid;
    assign pop        = r_out_valid && o_res.ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    // byte parser
    frp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_rx_byte    (i_rx.rx_byte),
        .i_max_length (r_max_length),
        .o_res_valid  (push),
        .o_res        (new_res)
    );

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload of the two stages
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end
    end

    // result channel
    assign o_res.valid         = r_out_valid;
    assign o_res.data_byte     = r_out.data_byte;
    assign o_res.last          = r_out.last;
    assign o_res.status        = r_out.status;
    assign o_res.packet_length = r_out.packet_length;

    // skid stage only fills behind a held output
    `FRP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    // a full skid stage drains into the output on a pop
    `FRP_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && o_res.ready, r_out_valid && !r_skid_valid, "skid did not drain")
    // payload results carry ok status
    `FRP_ASSERT_NOW(a_payload_ok, i_clk, i_rst_n, r_out_valid && !r_out.last, r_out.status == ST_OK, "payload byte with error status")
    // status results carry a zero data byte
    `FRP_ASSERT_NOW(a_status_zero, i_clk, i_rst_n, r_out_valid && r_out.last, r_out.data_byte == 8'd0, "status result with data byte")

endmodule

FILE: tb/framed_packet_receiver_top_test.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_top_test
// drives framed byte streams into the receiver and checks every result
// request against a cycle-free software copy of the parser and checksum;
// covers sync hunting, length limits, zero-length and checksum errors,
// with random source gaps and sink stalls
// ----------------------------------------------------------------------------
module framed_packet_receiver_top_test;
    import frp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK
    } t_rx_phase;

    localparam int unsigned TIMEOUT_CYCLES = 500_000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_BYTES   = 560;
    localparam logic [31:0] SYNC_WORD      = {SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    frp_in_if  rx_if ();
    frp_out_if res_if ();

    framed_packet_receiver_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    // parser copy used for prediction
    t_rx_phase   rx_phase;
    logic [1:0]  sync_pos;
    logic [7:0]  len_high;
    logic [15:0] hdr_len;
    logic [15:0] bytes_left;
    logic [31:0] run_sum;
    logic [15:0] max_len_cfg;

    t_result     result_q[$];
    int          err_count;
    int unsigned cycle_count = 0;
    int          frame_bytes;
    bit          gaps_on;
    bit          stall_on;

    // one checksum step: add with wrap, then rotate-like mix
    function automatic logic [31:0] csum_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0]        t;
        logic signed [31:0] sr;
        t  = acc + {24'd0, b};
        sr = t;
        sr = sr >>> 23;
        return {t[30:0], 1'b0} ^ sr;
    endfunction

    function automatic logic [7:0] csum_fold(input logic [31:0] acc);
        return acc[7:0] ^ acc[15:8] ^ acc[23:16];
    endfunction

    task automatic push_result(input logic [7:0] data, input logic last,
                               input logic [1:0] st, input logic [15:0] len);
        t_result r;
        r.data_byte     = data;
        r.last          = last;
        r.status        = st;
        r.packet_length = len;
        result_q.push_back(r);
    endtask

    // advance the parser copy by one accepted byte
    task automatic predict_rx_byte(input logic [7:0] b);
        case (rx_phase)
            PH_HUNT: begin
                if (b != SYNC_WORD[8 * (3 - sync_pos) +: 8]) begin
                    sync_pos = 2'd0;
                end else if (sync_pos == 2'd3) begin
                    sync_pos = 2'd0;
                    run_sum  = SUM_SEED;
                    rx_phase = PH_LEN_HI;
                end else begin
                    sync_pos = sync_pos + 2'd1;
                end
            end
            PH_LEN_HI: begin
                len_high = b;
                run_sum  = csum_step(run_sum, b);
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_len = {len_high, b};
                run_sum = csum_step(run_sum, b);
                if (hdr_len > max_len_cfg) begin
                    rx_phase = PH_HUNT;
                    sync_pos = 2'd0;
                    push_result(8'h00, 1'b1, ST_LEN_ERR, hdr_len);
                end else begin
                    bytes_left = hdr_len;
                    rx_phase   = (hdr_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                run_sum    = csum_step(run_sum, b);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    rx_phase = PH_CHECK;
                end
                push_result(b, 1'b0, ST_OK, hdr_len);
            end
            PH_CHECK: begin
                push_result(8'h00, 1'b1, (csum_fold(run_sum) == b) ? ST_OK : ST_SUM_ERR,
                            hdr_len);
                rx_phase = PH_HUNT;
                sync_pos = 2'd0;
            end
            default: begin
                rx_phase = PH_HUNT;
                sync_pos = 2'd0;
            end
        endcase
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sink side: ready with random stall bursts
    initial begin : sink_stall
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                res_if.ready = 1'b0;
                stall_left   = $urandom_range(0, 6);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // compare each result request with the oldest expectation
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data=%02h last=%0d status=%0d len=%0d",
                         $time, res_if.data_byte, res_if.last, res_if.status,
                         res_if.packet_length);
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (res_if.data_byte !== want.data_byte || res_if.last !== want.last ||
                    res_if.status !== want.status ||
                    res_if.packet_length !== want.packet_length) begin
                    $display("%0t: result mismatch, expected data=%02h last=%0d status=%0d len=%0d",
                             $time, want.data_byte, want.last, want.status,
                             want.packet_length);
                    $display("%0t: result mismatch, actual   data=%02h last=%0d status=%0d len=%0d",
                             $time, res_if.data_byte, res_if.last, res_if.status,
                             res_if.packet_length);
                    err_count++;
                end
            end
        end
    end

    // one byte request, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            rx_if.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge clk); while (!rx_if.ready);
        predict_rx_byte(b);
    endtask

    // stop sending and wait until every expected result is out
    task automatic wait_all_results;
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (result_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        wait_all_results();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we      = 1'b0;
        max_len_cfg = value;
    endtask

    // sync, header, payload and checksum; fill < 0 gives random payload,
    // cut >= 0 stops after that many payload bytes
    task automatic send_frame(input logic [15:0] len, input bit bad_sum, input int fill,
                              input int cut);
        logic [31:0] acc;
        logic [7:0]  b;
        int          i;
        acc = SUM_SEED;
        for (i = 0; i < 4; i++) begin
            send_byte(SYNC_WORD[8 * (3 - i) +: 8]);
        end
        send_byte(len[15:8]);
        acc = csum_step(acc, len[15:8]);
        send_byte(len[7:0]);
        acc = csum_step(acc, len[7:0]);
        frame_bytes += 6;
        if (len > max_len_cfg) begin
            return;
        end
        for (i = 0; i < len; i++) begin
            if (cut >= 0 && i >= cut) begin
                return;
            end
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            send_byte(b);
            acc = csum_step(acc, b);
            frame_bytes++;
        end
        b = csum_fold(acc);
        if (bad_sum) begin
            b ^= 8'($urandom_range(1, 255));
        end
        send_byte(b);
        frame_bytes++;
    endtask

    // partial sync then a breaking byte; leaves the hunter at the first sync byte
    task automatic send_line_noise;
        logic [7:0] b;
        int         k;
        int         i;
        k = $urandom_range(0, 3);
        for (i = 0; i < k; i++) begin
            send_byte(SYNC_WORD[8 * (3 - i) +: 8]);
        end
        if (k > 0 && $urandom_range(0, 1) == 0) begin
            b = SYNC_B0;
        end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == SYNC_B0 || b == SYNC_WORD[8 * (3 - k) +: 8]);
        end
        send_byte(b);
    endtask

    // sync mismatch, zero length, length error then immediate resync, bad checksum
    task automatic test_directed_frames;
        send_byte(SYNC_B0);
        send_byte(SYNC_B0);
        send_byte(SYNC_B1);
        send_byte(SYNC_B2);
        send_byte(SYNC_B3);
        send_frame(16'd0, 1'b0, -1, -1);
        send_frame(16'hFFFF, 1'b0, -1, -1);
        send_frame(16'd1, 1'b1, 8'hFF, -1);
    endtask

    // length limit at its extremes and at the boundary
    task automatic test_length_limits;
        write_max_length(16'd0);
        send_frame(16'd0, 1'b0, -1, -1);
        send_frame(16'd1, 1'b0, -1, -1);
        send_frame(16'd0, 1'b1, -1, -1);
        write_max_length(16'h0100);
        send_frame(16'h0100, 1'b0, 8'h00, -1);
        send_frame(16'h0101, 1'b0, -1, -1);
        write_max_length(16'hFFFF);
        send_frame(16'd5, 1'b0, -1, -1);
        send_frame(16'd3, 1'b1, -1, -1);
    endtask

    // random frames with noise, truncation and pauses until the byte goal
    task automatic run_random_frames(input int goal, input bit allow_idle);
        logic [15:0] len;
        int          pick;
        int          lim;
        int          cut;
        while (frame_bytes < goal) begin
            if (allow_idle && $urandom_range(0, 14) == 0) begin
                gaps_on  = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_line_noise();
            end
            pick = $urandom_range(0, 99);
            lim  = (max_len_cfg < 16'd10) ? int'(max_len_cfg) : 10;
            if (pick < 8 && max_len_cfg != 16'hFFFF) begin
                len = 16'($urandom_range(int'(max_len_cfg) + 1, 65535));
            end else if (pick < 14) begin
                len = (max_len_cfg <= 16'd48) ? max_len_cfg : 16'($urandom_range(11, 48));
            end else begin
                len = 16'($urandom_range(0, lim));
            end
            cut = ($urandom_range(0, 29) == 0 && len > 16'd1) ?
                  $urandom_range(0, int'(len) - 1) : -1;
            send_frame(len, ($urandom_range(0, 4) == 0), -1, cut);
            if (allow_idle && $urandom_range(0, 14) == 0) begin
                wait_all_results();
            end
        end
    endtask

    task automatic test_random_traffic;
        int quarter;
        quarter = RANDOM_BYTES / 4;
        frame_bytes = 0;
        write_max_length(MAX_LENGTH_RESET);
        run_random_frames(quarter, 1'b1);
        write_max_length(16'($urandom_range(0, 24)));
        run_random_frames(2 * quarter, 1'b1);
        write_max_length(16'hFFFF);
        run_random_frames(3 * quarter, 1'b1);
        // closing stretch runs at full rate on both sides
        write_max_length(16'($urandom_range(1, 60)));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_random_frames(RANDOM_BYTES, 1'b0);
    endtask

    // main sequence
    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        err_count     = 0;
        frame_bytes   = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        rx_phase      = PH_HUNT;
        sync_pos      = 2'd0;
        len_high      = 8'h00;
        hdr_len       = 16'd0;
        bytes_left    = 16'd0;
        run_sum       = SUM_SEED;
        max_len_cfg   = MAX_LENGTH_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_length_limits();
        test_random_traffic();

        wait_all_results();
        if (err_count == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/frp_pkg.sv
rtl/core/frp_in_if.sv
rtl/core/frp_out_if.sv
rtl/core/frp_parser.sv
rtl/core/framed_packet_receiver_top.sv
tb/framed_packet_receiver_top_test.sv
